>>> rtl/lrup_pkg.sv
// Shared types and constants for the LRU page replacement unit.
// No dependencies; every other file imports this package.
package lrup_pkg;

    localparam int unsigned PAGE_W  = 8;
    localparam int unsigned FAULT_W = 16;
    localparam int unsigned CFG_W   = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    // Request: one page reference.
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last_reference;
    } t_req;

    // Result: one per request.
    typedef struct packed {
        logic               hit;
        logic [FAULT_W-1:0] fault_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic               done_res;
    } t_res;

    // Per-cell control from the top level.
    typedef struct packed {
        logic write;      // request accepted this cycle
        logic found;      // page resident somewhere in the stack
        logic evict;      // miss with all frames used
        logic valid;      // slot index below fill count
        logic at_top;     // slot receives the referenced page
        logic below_top;  // slot lies under the top slot
    } t_cell_ctl;

endpackage

>>> rtl/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit: request/result handshake,
// fill count, fault counter and the chain of lrup_cell slots. Uses lrup_pkg.
//
// Usage:
//   Requests: drive i_req (page, last_reference) and raise start; a request
//   is taken at each rising edge with start high and busy low. busy stays
//   low, so one request per cycle is sustained.
//   Results: o_res is valid for exactly one cycle with o_res_strobe high,
//   the cycle after its request was taken (throughput 1/cycle).
//   There is no back pressure; the receiver must take every result.
//   Config: frames_in_use is written through i_cfg_data when i_cfg_valid
//   and o_cfg_ready are high; o_cfg_ready is always high. Write only while
//   no request is in flight. 0 acts as 1, values above FRAMES act as FRAMES.
//   The rate is set by the combinational compare/shift across the cell chain:
//   every slot compares the page, the match ripples up the chain, and all
//   slots update at the same edge.
//   Reset (i_rst_n low, synchronous): fill count and fault count clear,
//   frames_in_use returns to 8, no result strobe. Slot contents are not
//   cleared; slots at or above the fill count are never searched.
//   A request with last_reference set empties the stack and fault count
//   after its own result, starting a new reference string.
module lru_page_replacement_unit #(
    parameter int unsigned FRAMES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lrup_pkg::t_req             i_req,
    output logic                       o_res_strobe,
    output lrup_pkg::t_res             o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lrup_pkg::CFG_W-1:0] i_cfg_data
);
    import lrup_pkg::*;

    localparam int unsigned CW = $clog2(FRAMES + 1);

    logic [CFG_W-1:0]   r_frames_in_use;
    logic [CW-1:0]      r_filled;
    logic [CW-1:0]      n_filled;
    logic [FAULT_W-1:0] r_faults;
    logic [FAULT_W-1:0] n_faults;
    logic               r_res_strobe;
    t_res               r_res;
    t_res               n_res;

    logic               w_accept;
    logic [CW-1:0]      w_cap;
    logic               w_found;
    logic               w_evict;
    logic [CW-1:0]      w_top_idx;
    logic [FRAMES:0]    w_seen;
    logic [PAGE_W-1:0]  w_page [FRAMES];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // clamp capacity to 1..FRAMES
    always_comb begin
        if (r_frames_in_use == '0) begin
            w_cap = CW'(1);
        end else if (32'(r_frames_in_use) > 32'(FRAMES)) begin
            w_cap = CW'(FRAMES);
        end else begin
            w_cap = CW'(r_frames_in_use);
        end
    end

    assign w_found   = w_seen[FRAMES];
    assign w_evict   = !w_found && (r_filled >= w_cap);
    // hit/evict: top is filled-1; append: top is filled
    assign w_top_idx = (w_found || w_evict) ? (r_filled - CW'(1)) : r_filled;

    assign w_seen[0] = 1'b0;

    for (genvar k = 0; k < FRAMES; k++) begin : g_cell
        t_cell_ctl         w_ctl;
        logic [PAGE_W-1:0] w_upper;

        assign w_ctl.write     = w_accept;
        assign w_ctl.found     = w_found;
        assign w_ctl.evict     = w_evict;
        assign w_ctl.valid     = CW'(k) < r_filled;
        assign w_ctl.at_top    = CW'(k) == w_top_idx;
        assign w_ctl.below_top = CW'(k) < w_top_idx;

        // top cell has no upper neighbor; it never shifts
        if (k == FRAMES - 1) begin : g_last
            assign w_upper = i_req.page;
        end else begin : g_mid
            assign w_upper = w_page[k+1];
        end

        lrup_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_page       (i_req.page),
            .i_upper_page (w_upper),
            .i_seen       (w_seen[k]),
            .o_seen       (w_seen[k+1]),
            .o_page       (w_page[k])
        );
    end

    always_comb begin
        n_filled = r_filled;
        n_faults = r_faults;
        if (w_accept) begin
            if (i_req.last_reference) begin
                n_filled = '0;
                n_faults = '0;
            end else begin
                if (!w_found && !w_evict) begin
                    n_filled = r_filled + CW'(1);
                end
                if (!w_found && (r_faults != FAULT_MAX)) begin
                    n_faults = r_faults + FAULT_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_res.hit           = w_found;
        n_res.fault_index   = r_faults;
        n_res.evicted_valid = w_evict;
        n_res.evicted_page  = w_evict ? w_page[0] : '0;
        n_res.done_res      = i_req.last_reference;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
            r_filled        <= '0;
            r_faults        <= '0;
            r_res_strobe    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_frames_in_use <= i_cfg_data;
            end
            r_filled     <= n_filled;
            r_faults     <= n_faults;
            r_res_strobe <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_filled) <= 32'(FRAMES))
        else $error("fill count above frame count");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_res_strobe)
        else $error("accepted request produced no result");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !(o_res.hit && o_res.evicted_valid))
        else $error("hit reported together with eviction");

    a_hit_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_found && !i_req.last_reference) |=> r_filled == $past(r_filled))
        else $error("hit changed fill count");
`endif

endmodule

>>> rtl/lrup_cell.sv
// One recency stack slot: compare against the request, pass the match chain
// upward, load the request page at the top or the upper neighbor's page on a shift. Uses lrup_pkg.
module lrup_cell (
    input  logic                       i_clk,
    input  lrup_pkg::t_cell_ctl        i_ctl,
    input  logic [lrup_pkg::PAGE_W-1:0] i_page,
    input  logic [lrup_pkg::PAGE_W-1:0] i_upper_page,
    input  logic                       i_seen,
    output logic                       o_seen,
    output logic [lrup_pkg::PAGE_W-1:0] o_page
);
    import lrup_pkg::*;

    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] n_page;
    logic              w_match;
    logic              w_shift;

    assign w_match = i_ctl.valid && (r_page == i_page);
    assign o_seen  = i_seen | w_match;
    assign o_page  = r_page;

    // at or above the hit slot (or everything on eviction), under the top
    assign w_shift = (i_ctl.found ? o_seen : i_ctl.evict) && i_ctl.below_top;

    always_comb begin
        n_page = r_page;
        if (i_ctl.write) begin
            if (i_ctl.at_top) begin
                n_page = i_page;
            end else if (w_shift) begin
                n_page = i_upper_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule
